FILE: hw/rtl/gptrs_pkg.sv
// Package: shared types and constants for the grouped point table radius search unit.
package gptrs_pkg;

	localparam int MaxStarts = 16;
	localparam int MaxEnds = 16;

	localparam logic [1:0] OP_ADD_START = 2'd0;
	localparam logic [1:0] OP_ADD_END = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_FIND = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0] operation;
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
		logic signed [15:0] coord_z;
		logic [3:0] start_index;
		logic [3:0] end_index;
		logic whole_start;
		logic [15:0] tolerance;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic found;
		logic [3:0] found_start;
		logic found_is_start;
		logic [3:0] found_end;
	} out_item_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} point_t;

	// controller to datapath command codes
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_WR_START,
		CMD_WR_END,
		CMD_MOVE_START,
		CMD_MOVE_END,
		CMD_RD_START,
		CMD_RD_END
	} cmd_code_t;

endpackage

FILE: hw/rtl/grouped_point_table_radius_search_unit.sv
// Top level: grouped point table with fixed-radius search.
// A find reads points until the first match; with no starts or zero radius it skips the scan.
// A whole-start delete moves every later start down, with all MAX_ENDS end slots of each;
// a one-end delete shifts the later ends of that start down.
// One transaction at a time, the next one taken only after the result has been accepted.
// Reset clears counts and control; point memories stay undefined until written.
module grouped_point_table_radius_search_unit #(
	parameter int MAX_STARTS = gptrs_pkg::MaxStarts,
	parameter int MAX_ENDS = gptrs_pkg::MaxEnds
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input gptrs_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output gptrs_pkg::out_item_t out_item
);

	localparam int SW = (MAX_STARTS > 1) ? $clog2(MAX_STARTS) : 1;
	localparam int EW = (MAX_ENDS > 1) ? $clog2(MAX_ENDS) : 1;

	gptrs_pkg::cmd_code_t cmd;
	logic [SW-1:0] cmd_si, cmd_si2;
	logic [EW-1:0] cmd_ei, cmd_ei2;
	gptrs_pkg::point_t query;
	logic [15:0] tolerance;
	logic hit;

	gptrs_ctrl #(.MAX_STARTS(MAX_STARTS), .MAX_ENDS(MAX_ENDS)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .in_item, .out_valid, .out_stall,
		.out_item, .cmd, .cmd_si, .cmd_ei, .cmd_si2, .cmd_ei2, .query, .tolerance, .hit
	);

	gptrs_datapath #(.MAX_STARTS(MAX_STARTS), .MAX_ENDS(MAX_ENDS)) u_dp (
		.clk, .arst_n, .cmd, .cmd_si, .cmd_ei, .cmd_si2, .cmd_ei2, .query, .tolerance, .hit
	);

endmodule

FILE: hw/rtl/gptrs_datapath.sv
// Datapath: point memories, distance unit and match flag.
module gptrs_datapath #(
	parameter int MAX_STARTS = gptrs_pkg::MaxStarts,
	parameter int MAX_ENDS = gptrs_pkg::MaxEnds,
	localparam int SW = (MAX_STARTS > 1) ? $clog2(MAX_STARTS) : 1,
	localparam int EW = (MAX_ENDS > 1) ? $clog2(MAX_ENDS) : 1
) (
	input logic clk,
	input logic arst_n,
	input gptrs_pkg::cmd_code_t cmd,
	input logic [SW-1:0] cmd_si,
	input logic [EW-1:0] cmd_ei,
	input logic [SW-1:0] cmd_si2,
	input logic [EW-1:0] cmd_ei2,
	input gptrs_pkg::point_t query,
	input logic [15:0] tolerance,
	output logic hit
);

	localparam int AW = (MAX_STARTS * MAX_ENDS > 1) ? $clog2(MAX_STARTS * MAX_ENDS) : 1;

	gptrs_pkg::point_t start_mem [MAX_STARTS];
	gptrs_pkg::point_t end_mem [MAX_STARTS*MAX_ENDS];
	gptrs_pkg::point_t start_rd_q;
	gptrs_pkg::point_t end_rd_q;
	logic rd_s1;
	logic rd_is_end_s1;
	logic [33:0] sq_x_s2, sq_y_s2, sq_z_s2;
	logic rd_s2;
	logic [31:0] tol2_q;
	logic [35:0] sum;
	logic signed [16:0] dx, dy, dz;
	logic [16:0] ax, ay, az;
	gptrs_pkg::point_t rp;

	function automatic logic [AW-1:0] eaddr(input logic [SW-1:0] s, input logic [EW-1:0] e);
		return AW'(AW'(s) * AW'(MAX_ENDS) + AW'(e));
	endfunction

	always_ff @(posedge clk) begin
		case (cmd)
			gptrs_pkg::CMD_WR_START: start_mem[cmd_si] <= query;
			gptrs_pkg::CMD_WR_END: end_mem[eaddr(cmd_si, cmd_ei)] <= query;
			gptrs_pkg::CMD_MOVE_START: start_mem[cmd_si] <= start_rd_q;
			gptrs_pkg::CMD_MOVE_END: end_mem[eaddr(cmd_si, cmd_ei)] <= end_rd_q;
			default: ;
		endcase
		start_rd_q <= start_mem[cmd_si2];
		end_rd_q <= end_mem[eaddr(cmd_si2, cmd_ei2)];
		tol2_q <= 32'(tolerance) * 32'(tolerance);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			rd_s2 <= 1'b0;
			rd_is_end_s1 <= 1'b0;
		end else begin
			rd_s1 <= (cmd == gptrs_pkg::CMD_RD_START) || (cmd == gptrs_pkg::CMD_RD_END);
			rd_is_end_s1 <= (cmd == gptrs_pkg::CMD_RD_END);
			rd_s2 <= rd_s1;
		end
	end

	always_comb begin
		rp = rd_is_end_s1 ? end_rd_q : start_rd_q;
		dx = 17'(rp.x) - 17'(query.x);
		dy = 17'(rp.y) - 17'(query.y);
		dz = 17'(rp.z) - 17'(query.z);
		ax = dx[16] ? 17'(-dx) : 17'(dx);
		ay = dy[16] ? 17'(-dy) : 17'(dy);
		az = dz[16] ? 17'(-dz) : 17'(dz);
		sum = 36'(sq_x_s2) + 36'(sq_y_s2) + 36'(sq_z_s2);
		hit = rd_s2 && (sum < 36'(tol2_q));
	end

	always_ff @(posedge clk) begin
		sq_x_s2 <= 34'(ax) * 34'(ax);
		sq_y_s2 <= 34'(ay) * 34'(ay);
		sq_z_s2 <= 34'(az) * 34'(az);
	end

endmodule

FILE: hw/rtl/gptrs_ctrl.sv
// Controller: operation sequencing, counts, scan and shift control.
module gptrs_ctrl #(
	parameter int MAX_STARTS = gptrs_pkg::MaxStarts,
	parameter int MAX_ENDS = gptrs_pkg::MaxEnds,
	localparam int SW = (MAX_STARTS > 1) ? $clog2(MAX_STARTS) : 1,
	localparam int EW = (MAX_ENDS > 1) ? $clog2(MAX_ENDS) : 1,
	localparam int SCW = $clog2(MAX_STARTS + 1),
	localparam int ECW = $clog2(MAX_ENDS + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input gptrs_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output gptrs_pkg::out_item_t out_item,
	output gptrs_pkg::cmd_code_t cmd,
	output logic [SW-1:0] cmd_si,
	output logic [EW-1:0] cmd_ei,
	output logic [SW-1:0] cmd_si2,
	output logic [EW-1:0] cmd_ei2,
	output gptrs_pkg::point_t query,
	output logic [15:0] tolerance,
	input logic hit
);

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_MVS_RD, S_MVS_WR, S_MVE_RD, S_MVE_WR,
		S_DEL_END_RD, S_DEL_END_WR, S_FIND_ISSUE, S_FIND_DRAIN, S_DONE
	} state_t;

	state_t state_q;
	gptrs_pkg::in_item_t item_q;
	logic [SCW-1:0] start_count_q;
	logic [ECW-1:0] end_counts_q [MAX_STARTS];
	logic [SCW-1:0] i_q;
	logic [ECW-1:0] j_q;
	logic scan_end_q;
	logic [1:0] drain_q;
	logic [SW-1:0] hs_s1, hs_s2;
	logic [EW-1:0] he_s1, he_s2;
	logic hstart_s1, hstart_s2;
	logic hv_s1, hv_s2;
	logic out_valid_q;
	gptrs_pkg::out_item_t out_q;
	logic [SCW-1:0] si_w;
	logic [ECW-1:0] ei_w;
	logic [ECW-1:0] cur_cnt;
	logic scan_hit;

	assign in_stall = (state_q != S_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;
	assign out_item = out_q;
	assign query.x = item_q.coord_x;
	assign query.y = item_q.coord_y;
	assign query.z = item_q.coord_z;
	assign tolerance = item_q.tolerance;
	assign si_w = SCW'(item_q.start_index);
	assign ei_w = ECW'(item_q.end_index);
	assign cur_cnt = end_counts_q[i_q[SW-1:0]];
	assign scan_hit = hv_s2 && hit && !out_q.found;

	always_comb begin
		cmd = gptrs_pkg::CMD_NONE;
		cmd_si = i_q[SW-1:0];
		cmd_ei = j_q[EW-1:0];
		cmd_si2 = i_q[SW-1:0];
		cmd_ei2 = j_q[EW-1:0];
		case (state_q)
			S_DISPATCH: begin
				if (item_q.operation == gptrs_pkg::OP_ADD_START &&
						start_count_q < SCW'(MAX_STARTS)) begin
					cmd = gptrs_pkg::CMD_WR_START;
					cmd_si = start_count_q[SW-1:0];
				end else if (item_q.operation == gptrs_pkg::OP_ADD_END &&
						si_w < start_count_q &&
						end_counts_q[si_w[SW-1:0]] < ECW'(MAX_ENDS)) begin
					cmd = gptrs_pkg::CMD_WR_END;
					cmd_si = si_w[SW-1:0];
					cmd_ei = end_counts_q[si_w[SW-1:0]][EW-1:0];
				end
			end
			S_MVS_RD: begin
				cmd_si2 = SW'(i_q + 1'b1);
			end
			S_MVS_WR: begin
				cmd = gptrs_pkg::CMD_MOVE_START;
			end
			S_MVE_RD: begin
				cmd_si2 = SW'(i_q + 1'b1);
			end
			S_MVE_WR: begin
				cmd = gptrs_pkg::CMD_MOVE_END;
			end
			S_DEL_END_RD: begin
				cmd_si2 = si_w[SW-1:0];
				cmd_ei2 = EW'(j_q + 1'b1);
			end
			S_DEL_END_WR: begin
				cmd = gptrs_pkg::CMD_MOVE_END;
				cmd_si = si_w[SW-1:0];
			end
			S_FIND_ISSUE: begin
				cmd = scan_end_q ? gptrs_pkg::CMD_RD_END : gptrs_pkg::CMD_RD_START;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) item_q <= in_item;
		hs_s1 <= i_q[SW-1:0];
		he_s1 <= j_q[EW-1:0];
		hstart_s1 <= !scan_end_q;
		hs_s2 <= hs_s1;
		he_s2 <= he_s1;
		hstart_s2 <= hstart_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_count_q <= '0;
			for (int k = 0; k < MAX_STARTS; k++) end_counts_q[k] <= '0;
			i_q <= '0;
			j_q <= '0;
			scan_end_q <= 1'b0;
			drain_q <= '0;
			hv_s1 <= 1'b0;
			hv_s2 <= 1'b0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			hv_s1 <= (state_q == S_FIND_ISSUE);
			hv_s2 <= hv_s1;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						out_q <= '0;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					state_q <= S_DONE;
					case (item_q.operation)
						gptrs_pkg::OP_ADD_START: begin
							if (start_count_q >= SCW'(MAX_STARTS)) begin
								out_q.status <= gptrs_pkg::ST_FULL;
							end else begin
								end_counts_q[start_count_q[SW-1:0]] <= '0;
								start_count_q <= start_count_q + 1'b1;
							end
						end
						gptrs_pkg::OP_ADD_END: begin
							if (si_w >= start_count_q) begin
								out_q.status <= gptrs_pkg::ST_RANGE;
							end else if (end_counts_q[si_w[SW-1:0]] >= ECW'(MAX_ENDS)) begin
								out_q.status <= gptrs_pkg::ST_FULL;
							end else begin
								end_counts_q[si_w[SW-1:0]] <=
									end_counts_q[si_w[SW-1:0]] + 1'b1;
							end
						end
						gptrs_pkg::OP_DELETE: begin
							if (si_w >= start_count_q) begin
								out_q.status <= gptrs_pkg::ST_RANGE;
							end else if (item_q.whole_start) begin
								i_q <= si_w;
								state_q <= S_MVS_RD;
							end else if (ei_w >= end_counts_q[si_w[SW-1:0]]) begin
								out_q.status <= gptrs_pkg::ST_RANGE;
							end else begin
								j_q <= ei_w;
								state_q <= S_DEL_END_RD;
							end
						end
						default: begin
							i_q <= '0;
							j_q <= '0;
							scan_end_q <= 1'b0;
							state_q <= (start_count_q == '0 || item_q.tolerance == '0) ?
								S_DONE : S_FIND_ISSUE;
						end
					endcase
				end
				// shift starts down: point, count, then the end list
				S_MVS_RD: begin
					if (i_q + 1'b1 >= start_count_q) begin
						start_count_q <= start_count_q - 1'b1;
						end_counts_q[SW'(start_count_q - 1'b1)] <= '0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_MVS_WR;
					end
				end
				S_MVS_WR: begin
					end_counts_q[i_q[SW-1:0]] <= end_counts_q[SW'(i_q + 1'b1)];
					j_q <= '0;
					state_q <= S_MVE_RD;
				end
				S_MVE_RD: state_q <= S_MVE_WR;
				S_MVE_WR: begin
					if (j_q == ECW'(MAX_ENDS - 1)) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
						state_q <= S_MVS_RD;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_MVE_RD;
					end
				end
				S_DEL_END_RD: begin
					if (j_q + 1'b1 >= end_counts_q[si_w[SW-1:0]]) begin
						end_counts_q[si_w[SW-1:0]] <= end_counts_q[si_w[SW-1:0]] - 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_DEL_END_WR;
					end
				end
				S_DEL_END_WR: begin
					j_q <= j_q + 1'b1;
					state_q <= S_DEL_END_RD;
				end
				S_FIND_ISSUE: begin
					if (scan_hit) begin
						state_q <= S_DONE;
					end else if (!scan_end_q) begin
						if (cur_cnt != '0) begin
							scan_end_q <= 1'b1;
							j_q <= '0;
						end else if (i_q + 1'b1 < start_count_q) begin
							i_q <= i_q + 1'b1;
						end else begin
							state_q <= S_FIND_DRAIN;
						end
					end else if (j_q + 1'b1 < cur_cnt) begin
						j_q <= j_q + 1'b1;
					end else if (i_q + 1'b1 < start_count_q) begin
						scan_end_q <= 1'b0;
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						state_q <= S_FIND_DRAIN;
					end
					drain_q <= '0;
				end
				S_FIND_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (scan_hit || drain_q == 2'd2) state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// take first hit of the scan
			if (scan_hit && (state_q == S_FIND_ISSUE || state_q == S_FIND_DRAIN)) begin
				out_q.found <= 1'b1;
				out_q.found_start <= 4'(hs_s2);
				out_q.found_is_start <= hstart_s2;
				out_q.found_end <= hstart_s2 ? 4'd0 : 4'(he_s2);
			end
		end
	end

endmodule
